// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define CHA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/cha_pkg.sv =====
// package for the cell hit aggregator
// request and result payload types, shared constants
`default_nettype none
package cha_pkg;
    localparam int LAYER_W = 7;
    localparam int CELLF_W = 9;
    localparam int VAL_W   = 16;
    localparam int MOM_W   = 20;
    localparam int SQ_W    = 42;
    localparam logic [VAL_W-1:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [LAYER_W-1:0]   layer;
        logic [CELLF_W-1:0]   cell_req;
        logic [VAL_W-1:0]     drift_ticks;
        logic [VAL_W-1:0]     distance;
        logic signed [MOM_W-1:0] mom_x;
        logic signed [MOM_W-1:0] mom_y;
        logic signed [MOM_W-1:0] mom_z;
        logic                 last_hit;
    } hit_t;

    typedef struct packed {
        logic [LAYER_W-1:0] out_layer;
        logic [CELLF_W-1:0] out_cell;
        logic [VAL_W-1:0]   time_min;
        logic [VAL_W-1:0]   time_max;
        logic [VAL_W-1:0]   dist_min;
        logic [VAL_W-1:0]   dist_max;
        logic [VAL_W-1:0]   run_now;
        logic [VAL_W-1:0]   run_longest;
        logic [VAL_W-1:0]   hits_total;
        logic [MOM_W-1:0]   mom_magnitude;
        logic               last_of_event;
        logic               overflow;
    } result_t;

    // per-cell statistics carried in each cell
    typedef struct packed {
        logic [VAL_W-1:0] tmin;
        logic [VAL_W-1:0] tmax;
        logic [VAL_W-1:0] dmin;
        logic [VAL_W-1:0] dmax;
        logic [VAL_W-1:0] run;
        logic [VAL_W-1:0] run_max;
        logic [VAL_W-1:0] total;
        logic [MOM_W-1:0] mom;
    } stats_t;

    // command from the sequencer to every cell
    typedef struct packed {
        logic             upd;      // update the matching cell
        logic             alloc;    // write new entry into the tail cell
        logic             fold;     // fold run into longest on prev cell
        logic             shift;    // shift chain toward the head
        logic             restart;  // run restarts (return to known cell)
        logic [VAL_W-1:0] t;
        logic [VAL_W-1:0] d;
        logic [MOM_W-1:0] mom;
    } cell_cmd_t;

    function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] x);
        sat_inc = (x == SAT16) ? SAT16 : x + 16'd1;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/cha_isqrt.sv =====
// multi-cycle integer square root of the momentum squared sum
// uses cha_pkg; one result bit per cycle, one multiplier per cycle
`default_nettype none
module cha_isqrt import cha_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic signed [MOM_W-1:0] px,
    input  wire logic signed [MOM_W-1:0] py,
    input  wire logic signed [MOM_W-1:0] pz,
    output logic                        done,
    output logic [MOM_W-1:0]            root
);
    logic [2:0]       phase_reg, phase_next;
    logic [4:0]       bit_reg, bit_next;
    logic [MOM_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]  rem_reg, rem_next;
    logic [MOM_W:0]   res_reg, res_next;
    logic [SQ_W-1:0]  sq;
    logic [MOM_W-1:0] sel;
    logic [SQ_W-1:0]  trial;

    localparam logic [2:0] PH_IDLE = 3'd0, PH_X = 3'd1, PH_Y = 3'd2,
                           PH_Z = 3'd3, PH_ROOT = 3'd4;

    function automatic logic [MOM_W-1:0] abs20(input logic signed [MOM_W-1:0] v);
        abs20 = v[MOM_W-1] ? MOM_W'(-v) : v;
    endfunction

    always_comb begin
        unique case (phase_reg)
            PH_X:    sel = ax_reg;
            PH_Y:    sel = ay_reg;
            default: sel = az_reg;
        endcase
        sq = SQ_W'(sel) * SQ_W'(sel);
        trial = SQ_W'({res_reg[MOM_W-1:0], 1'b0, 1'b1}) << (2 * bit_reg);
    end

    // restoring square root: res holds root bits above current
    always_comb begin
        phase_next = phase_reg;
        bit_next = bit_reg;
        sum_next = sum_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        done = 1'b0;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) begin
                    phase_next = PH_X;
                    sum_next = '0;
                end
            end
            PH_X, PH_Y: begin
                sum_next = sum_reg + sq;
                phase_next = phase_reg + 3'd1;
            end
            PH_Z: begin
                rem_next = sum_reg + sq;
                res_next = '0;
                bit_next = 5'(MOM_W);
                phase_next = PH_ROOT;
            end
            PH_ROOT: begin
                if (rem_reg >= trial) begin
                    rem_next = rem_reg - trial;
                    res_next = {res_reg[MOM_W-1:0], 1'b1};
                end else begin
                    res_next = {res_reg[MOM_W-1:0], 1'b0};
                end
                if (bit_reg == 5'd0) begin
                    phase_next = PH_IDLE;
                    done = 1'b1;
                end else begin
                    bit_next = bit_reg - 5'd1;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    // final root bit is included while done is high
    assign root = res_next[MOM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
        bit_reg <= bit_next;
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        if (phase_reg == PH_IDLE && start) begin
            ax_reg <= abs20(px);
            ay_reg <= abs20(py);
            az_reg <= abs20(pz);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cha_cell.sv =====
// one cell of the aggregation chain: holds one table entry
// uses cha_pkg; hands its entry to the neighbor toward the head on shift
`default_nettype none
module cha_cell import cha_pkg::*; #(
    parameter int KEY_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cell_cmd_t        cmd,
    input  wire logic [KEY_W-1:0] probe_key,
    input  wire logic             is_tail,
    input  wire logic             is_prev,
    input  wire logic [KEY_W-1:0] up_key,
    input  wire stats_t           up_stats,
    input  wire logic             up_valid,
    output logic [KEY_W-1:0]      key,
    output stats_t                stats,
    output logic                  valid,
    output logic                  hit
);
    logic [KEY_W-1:0] key_reg;
    stats_t           st_reg, st_next;
    logic             valid_reg;

    assign key = key_reg;
    assign stats = st_reg;
    assign valid = valid_reg;
    assign hit = valid_reg && (key_reg == probe_key);

    always_comb begin
        st_next = st_reg;
        if (cmd.fold && is_prev && st_reg.run_max < st_reg.run) begin
            st_next.run_max = st_reg.run;
        end
        if (cmd.upd && hit) begin
            if (st_reg.tmin > cmd.t) st_next.tmin = cmd.t;
            if (st_reg.tmax < cmd.t) st_next.tmax = cmd.t;
            if (st_reg.dmin > cmd.d) st_next.dmin = cmd.d;
            if (st_reg.dmax < cmd.d) st_next.dmax = cmd.d;
            st_next.total = sat_inc(st_reg.total);
            if (cmd.restart) begin
                st_next.run = 16'd1;
                st_next.mom = cmd.mom;
            end else begin
                st_next.run = sat_inc(st_reg.run);
            end
        end
        if (cmd.alloc && is_tail) begin
            st_next.tmin = cmd.t;
            st_next.tmax = cmd.t;
            st_next.dmin = cmd.d;
            st_next.dmax = cmd.d;
            st_next.run = 16'd1;
            st_next.run_max = 16'd1;
            st_next.total = 16'd1;
            st_next.mom = cmd.mom;
        end
        if (cmd.shift) begin
            st_next = up_stats;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.shift) begin
            valid_reg <= up_valid;
        end else if (cmd.alloc && is_tail) begin
            valid_reg <= 1'b1;
        end
        st_reg <= st_next;
        if (cmd.shift) begin
            key_reg <= up_key;
        end else if (cmd.alloc && is_tail) begin
            key_reg <= probe_key;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cell_hit_aggregator.sv =====
// cell hit aggregator top level: sequencer, cell chain, square root unit
// uses cha_pkg, cha_cell, cha_isqrt, assert_macros.svh
//
//  channel  dir  ports                       payload
//  s_       in   s_valid s_ready s_data      hit_t
//  m_       out  m_valid m_ready m_data      result_t
//
// a hit of the previous cell, or a dropped hit, goes through accept, probe and settle
// a hit that starts a run goes through accept, probe, squaring of x, y and z,
//   21 root bits, settle
// on the last hit the chain shifts one entry per accepted m_ request;
//   m_ready stalls the shift and s_ready stays low until the last result is taken
// reset clears entry valid bits at once; no clearing pass
`default_nettype none
`include "assert_macros.svh"
module cell_hit_aggregator import cha_pkg::*; #(
    parameter int MAX_CELLS = 64,
    parameter int CELL_BITS = 9
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire hit_t    s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);
    localparam int KEY_W = CELL_BITS + LAYER_W;
    localparam int IDX_W = $clog2(MAX_CELLS);
    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0, ST_PROBE = 3'd1, ST_ROOT = 3'd2,
                           ST_APPLY = 3'd3, ST_DRAIN = 3'd4;

    logic [2:0]       state_reg, state_next;
    hit_t             hit_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic             prev_valid_reg, prev_valid_next;
    logic             ovf_reg, ovf_next;
    logic             new_reg, new_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             mv_reg;
    result_t          mdata_reg;
    cell_cmd_t        cmd;
    logic [KEY_W-1:0] probe_key;
    logic             sq_start, sq_done;
    logic [MOM_W-1:0] sq_root;

    logic [KEY_W-1:0] keys    [MAX_CELLS+1];
    stats_t           stats   [MAX_CELLS+1];
    logic             valids  [MAX_CELLS+1];
    logic [MAX_CELLS-1:0] hits;
    logic             any_hit, prev_hit;
    logic [IDX_W-1:0] hit_idx;

    function automatic logic [CELL_BITS-1:0] s_data_key_cell(input logic [CELLF_W-1:0] c);
        logic [CELLF_W+CELL_BITS-1:0] w;
        w = (CELLF_W+CELL_BITS)'(c);
        s_data_key_cell = w[CELL_BITS-1:0];
    endfunction

    assign probe_key = {s_data_key_cell(hit_reg.cell_req), hit_reg.layer};

    assign keys[MAX_CELLS] = '0;
    assign stats[MAX_CELLS] = '0;
    assign valids[MAX_CELLS] = 1'b0;

    for (genvar g = 0; g < MAX_CELLS; g++) begin : g_cell
        cha_cell #(.KEY_W(KEY_W)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .probe_key(probe_key),
            .is_tail(count_reg == CNT_W'(g)),
            .is_prev(prev_reg == IDX_W'(g)),
            .up_key(keys[g+1]), .up_stats(stats[g+1]), .up_valid(valids[g+1]),
            .key(keys[g]), .stats(stats[g]), .valid(valids[g]), .hit(hits[g])
        );
    end

    always_comb begin
        hit_idx = '0;
        for (int i = MAX_CELLS - 1; i >= 0; i--) begin
            if (hits[i]) hit_idx = IDX_W'(i);
        end
    end
    assign any_hit = |hits;
    assign prev_hit = prev_valid_reg && hits[prev_reg];

    cha_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start),
        .px(hit_reg.mom_x), .py(hit_reg.mom_y), .pz(hit_reg.mom_z),
        .done(sq_done), .root(sq_root)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;
    assign m_data = mdata_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        prev_next = prev_reg;
        prev_valid_next = prev_valid_reg;
        ovf_next = ovf_reg;
        new_next = new_reg;
        left_next = left_reg;
        cmd = '0;
        cmd.t = hit_reg.drift_ticks;
        cmd.d = hit_reg.distance;
        cmd.mom = sq_root;
        sq_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PROBE;
            end
            ST_PROBE: begin
                if (prev_hit) begin
                    cmd.upd = 1'b1;
                    state_next = ST_APPLY;
                end else if (any_hit || count_reg < CNT_W'(MAX_CELLS)) begin
                    new_next = !any_hit;
                    sq_start = 1'b1;
                    state_next = ST_ROOT;
                end else begin
                    cmd.fold = prev_valid_reg;
                    ovf_next = 1'b1;
                    prev_valid_next = 1'b0;
                    state_next = ST_APPLY;
                end
            end
            ST_ROOT: begin
                if (sq_done) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                // settle cycle; a last hit folds its run and starts the drain
                state_next = ST_IDLE;
            end
            ST_DRAIN: begin
                if (!mv_reg || m_ready) begin
                    if (left_reg == '0) begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        prev_valid_next = 1'b0;
                        ovf_next = 1'b0;
                    end else begin
                        cmd.shift = 1'b1;
                        left_next = left_reg - CNT_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // run start is applied in the cycle the root finishes
        if (state_reg == ST_ROOT && sq_done) begin
            cmd.fold = prev_valid_reg;
            prev_valid_next = 1'b1;
            if (new_reg) begin
                cmd.alloc = 1'b1;
                prev_next = IDX_W'(count_reg);
                count_next = count_reg + CNT_W'(1);
            end else begin
                cmd.upd = 1'b1;
                cmd.restart = 1'b1;
                prev_next = hit_idx;
            end
        end
        if (state_reg == ST_APPLY && hit_reg.last_hit) begin
            cmd.fold = prev_valid_reg;
            prev_valid_next = 1'b0;
            left_next = count_reg;
            state_next = ST_DRAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            prev_valid_reg <= 1'b0;
            ovf_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            prev_valid_reg <= prev_valid_next;
            ovf_reg <= ovf_next;
            if (cmd.shift) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
        prev_reg <= prev_next;
        new_reg <= new_next;
        left_reg <= left_next;
        if (state_reg == ST_IDLE && s_valid) begin
            hit_reg <= s_data;
        end
        if (cmd.shift) begin
            mdata_reg.out_layer <= keys[0][LAYER_W-1:0];
            mdata_reg.out_cell <= CELLF_W'({{CELLF_W{1'b0}}, keys[0][KEY_W-1:LAYER_W]});
            mdata_reg.time_min <= stats[0].tmin;
            mdata_reg.time_max <= stats[0].tmax;
            mdata_reg.dist_min <= stats[0].dmin;
            mdata_reg.dist_max <= stats[0].dmax;
            mdata_reg.run_now <= stats[0].run;
            mdata_reg.run_longest <= stats[0].run_max;
            mdata_reg.hits_total <= stats[0].total;
            mdata_reg.mom_magnitude <= stats[0].mom;
            mdata_reg.last_of_event <= (left_reg == CNT_W'(1));
            mdata_reg.overflow <= ovf_reg;
        end
    end

    `CHA_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_CELLS))
    `CHA_ASSERT_IMP(a_hit_unique, aclk, aresetn, state_reg == ST_PROBE, $onehot0(hits))
    `CHA_ASSERT_NEXT(a_drain_done, aclk, aresetn,
        state_reg == ST_DRAIN && state_next == ST_IDLE, count_reg == '0)
endmodule
`default_nettype wire

// ===== dv/cell_hit_aggregator_test.sv =====
// testbench for cell_hit_aggregator: random and directed hit events, self checking
// depends on cha_pkg and the rtl top level; holds its own per-cell prediction
`timescale 1ns / 100ps
`default_nettype none

module cell_hit_aggregator_test import cha_pkg::*; ();

    class hit_scoreboard;
        localparam int CAP = 64;

        result_t       want_q[$];
        int            errors;
        logic [15:0]   key_tab   [CAP];
        logic [15:0]   tmin_tab  [CAP];
        logic [15:0]   tmax_tab  [CAP];
        logic [15:0]   dmin_tab  [CAP];
        logic [15:0]   dmax_tab  [CAP];
        logic [15:0]   run_tab   [CAP];
        logic [15:0]   runmax_tab[CAP];
        logic [15:0]   total_tab [CAP];
        logic [19:0]   mom_tab   [CAP];
        int            used;
        int            last_idx;
        bit            last_ok;
        bit            dropped;

        function new();
            errors   = 0;
            used     = 0;
            last_idx = 0;
            last_ok  = 0;
            dropped  = 0;
        endfunction

        function automatic logic [15:0] bump(logic [15:0] x);
            return (x == 16'hFFFF) ? x : x + 16'd1;
        endfunction

        function automatic logic [19:0] root_of(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'h1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r[19:0];
        endfunction

        function automatic logic [19:0] magnitude(logic signed [19:0] x,
                                                  logic signed [19:0] y,
                                                  logic signed [19:0] z);
            longint ax;
            longint ay;
            longint az;
            ax = (x < 0) ? -longint'(x) : longint'(x);
            ay = (y < 0) ? -longint'(y) : longint'(y);
            az = (z < 0) ? -longint'(z) : longint'(z);
            return root_of(64'(ax * ax + ay * ay + az * az));
        endfunction

        function void extremes(int e, logic [15:0] t, logic [15:0] d);
            if (tmin_tab[e] > t) tmin_tab[e] = t;
            if (tmax_tab[e] < t) tmax_tab[e] = t;
            if (dmin_tab[e] > d) dmin_tab[e] = d;
            if (dmax_tab[e] < d) dmax_tab[e] = d;
        endfunction

        function void fold_last();
            if (last_ok && runmax_tab[last_idx] < run_tab[last_idx])
                runmax_tab[last_idx] = run_tab[last_idx];
        endfunction

        function void note_hit(hit_t h);
            logic [15:0] key;
            int          hit_at;
            result_t     r;
            key = {h.cell_req, h.layer};
            if (last_ok && last_idx < used && key_tab[last_idx] == key) begin
                run_tab[last_idx]   = bump(run_tab[last_idx]);
                total_tab[last_idx] = bump(total_tab[last_idx]);
                extremes(last_idx, h.drift_ticks, h.distance);
            end else begin
                hit_at = used;
                for (int i = 0; i < used; i++) begin
                    if (key_tab[i] == key) begin
                        hit_at = i;
                        break;
                    end
                end
                fold_last();
                if (hit_at < used) begin
                    total_tab[hit_at] = bump(total_tab[hit_at]);
                    run_tab[hit_at]   = 1;
                    mom_tab[hit_at]   = magnitude(h.mom_x, h.mom_y, h.mom_z);
                    extremes(hit_at, h.drift_ticks, h.distance);
                    last_idx = hit_at;
                    last_ok  = 1;
                end else if (used < CAP) begin
                    key_tab[used]    = key;
                    tmin_tab[used]   = h.drift_ticks;
                    tmax_tab[used]   = h.drift_ticks;
                    dmin_tab[used]   = h.distance;
                    dmax_tab[used]   = h.distance;
                    run_tab[used]    = 1;
                    runmax_tab[used] = 1;
                    total_tab[used]  = 1;
                    mom_tab[used]    = magnitude(h.mom_x, h.mom_y, h.mom_z);
                    last_idx = used;
                    last_ok  = 1;
                    used++;
                end else begin
                    dropped = 1;
                    last_ok = 0;
                end
            end
            if (!h.last_hit) return;
            fold_last();
            for (int i = 0; i < used; i++) begin
                r.out_layer     = key_tab[i][6:0];
                r.out_cell      = key_tab[i][15:7];
                r.time_min      = tmin_tab[i];
                r.time_max      = tmax_tab[i];
                r.dist_min      = dmin_tab[i];
                r.dist_max      = dmax_tab[i];
                r.run_now       = run_tab[i];
                r.run_longest   = runmax_tab[i];
                r.hits_total    = total_tab[i];
                r.mom_magnitude = mom_tab[i];
                r.last_of_event = (i + 1 == used);
                r.overflow      = dropped;
                want_q.insert(want_q.size(), r);
            end
            used     = 0;
            last_idx = 0;
            last_ok  = 0;
            dropped  = 0;
        endfunction

        function void check_result(result_t got);
            result_t w;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            w = want_q.pop_front();
            if (got.out_layer !== w.out_layer || got.out_cell !== w.out_cell ||
                got.time_min !== w.time_min || got.time_max !== w.time_max ||
                got.dist_min !== w.dist_min || got.dist_max !== w.dist_max ||
                got.run_now !== w.run_now || got.run_longest !== w.run_longest ||
                got.hits_total !== w.hits_total || got.mom_magnitude !== w.mom_magnitude ||
                got.last_of_event !== w.last_of_event || got.overflow !== w.overflow) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch layer/cell exp %0d/%0d got %0d/%0d",
                             w.out_layer, w.out_cell, got.out_layer, got.out_cell);
                    $display("  tmin/tmax/dmin/dmax exp %h %h %h %h got %h %h %h %h",
                             w.time_min, w.time_max, w.dist_min, w.dist_max,
                             got.time_min, got.time_max, got.dist_min, got.dist_max);
                    $display("  run/longest/total/mom/last/ovf exp %h %h %h %h %b %b",
                             w.run_now, w.run_longest, w.hits_total, w.mom_magnitude,
                             w.last_of_event, w.overflow);
                    $display("  got %h %h %h %h %b %b", got.run_now, got.run_longest,
                             got.hits_total, got.mom_magnitude, got.last_of_event,
                             got.overflow);
                end
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 5000;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    hit_t    s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    hit_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int quiet_cycles   = 0;

    cell_hit_aggregator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_valid && m_ready) sb.check_result(m_data);
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [19:0] pick_mom();
        case ($urandom_range(7))
            0: return 20'h80000;
            1: return 20'h7FFFF;
            2: return 20'h00000;
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic send_hit(hit_t h);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= h;
        do @(posedge aclk); while (!s_ready);
        sb.note_hit(h);
    endtask

    task automatic send_simple(int layer, int cell_no, logic [15:0] t, logic [15:0] d,
                               logic [19:0] mx, logic [19:0] my, logic [19:0] mz, bit last);
        hit_t h;
        h.layer       = 7'(layer);
        h.cell_req    = 9'(cell_no);
        h.drift_ticks = t;
        h.distance    = d;
        h.mom_x       = mx;
        h.mom_y       = my;
        h.mom_z       = mz;
        h.last_hit    = last;
        send_hit(h);
    endtask

    // mostly short events over a small cell pool so repeats and returns are common
    task automatic random_event(output int sent);
        int   nhits;
        int   pool;
        hit_t h;
        nhits = $urandom_range(1, 14);
        pool  = $urandom_range(1, 5);
        for (int i = 0; i < nhits; i++) begin
            if ($urandom_range(4) == 0) begin
                h.layer    = 7'($urandom);
                h.cell_req = 9'($urandom);
            end else begin
                h.layer    = 7'($urandom_range(pool - 1));
                h.cell_req = ($urandom_range(1) == 0) ? 9'h000 : 9'h1FF;
            end
            h.drift_ticks = pick16();
            h.distance    = pick16();
            h.mom_x       = pick_mom();
            h.mom_y       = pick_mom();
            h.mom_z       = pick_mom();
            h.last_hit    = (i == nhits - 1) || ($urandom_range(19) == 0);
            send_hit(h);
        end
        sent = nhits;
    endtask

    // more distinct cells than the table holds, then a repeat of a dropped cell and a revisit of a stored cell
    task automatic overflow_event();
        for (int i = 0; i < 70; i++)
            send_simple(i, 9'h0AA, pick16(), pick16(), pick_mom(), pick_mom(), pick_mom(), 0);
        send_simple(69, 9'h0AA, pick16(), pick16(), pick_mom(), pick_mom(), pick_mom(), 0);
        send_simple(3, 9'h0AA, pick16(), pick16(), pick_mom(), pick_mom(), pick_mom(), 0);
        send_simple(3, 9'h0AA, pick16(), pick16(), pick_mom(), pick_mom(), pick_mom(), 1);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.want_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int sent;
        int total;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_simple(0, 0, 0, 0, 0, 0, 0, 1);
        send_simple(127, 9'h1FF, 16'hFFFF, 16'hFFFF, 20'h80000, 20'h80000, 20'h80000, 0);
        send_simple(127, 9'h1FF, 16'h0000, 16'h0000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 0);
        send_simple(127, 9'h1FF, 16'h8000, 16'h1234, 20'h00001, 20'h00000, 20'h00000, 0);
        send_simple(99, 9'h1FF, 16'h0100, 16'h0200, 20'h7FFFF, 20'h80000, 20'h00003, 0);
        send_simple(99, 9'h0FF, 16'h0101, 16'h0201, 20'h00000, 20'h00000, 20'h00000, 0);
        send_simple(127, 9'h1FF, 16'h0010, 16'hFFFE, 20'h12345, 20'hABCDE, 20'h00000, 0);
        send_simple(127, 9'h1FF, 16'h0011, 16'h0001, 20'h00000, 20'h00000, 20'h00000, 0);
        send_simple(99, 9'h1FF, 16'hFFFF, 16'h0000, 20'hFFFFF, 20'h00001, 20'h80000, 1);
        send_simple(1, 2, 16'h5555, 16'hAAAA, 20'h55555, 20'hAAAAA, 20'h55555, 0);
        send_simple(2, 1, 16'hAAAA, 16'h5555, 20'hAAAAA, 20'h55555, 20'hAAAAA, 0);
        send_simple(1, 2, 16'h0001, 16'h0001, 20'h00000, 20'h00000, 20'h00000, 1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (phase == 0) hold_cycles = 600;
            if (phase == 2 || phase == 3) overflow_event();
            total = 0;
            while (total < 57) begin
                random_event(sent);
                total += sent;
            end
            drain();
        end

        if (sb.errors == 0 && sb.want_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/cha_pkg.sv
rtl/cha_isqrt.sv
rtl/cha_cell.sv
rtl/cell_hit_aggregator.sv
dv/cell_hit_aggregator_test.sv
